### src/hkm_pkg.sv
// Package for the keyboard-report-to-MIDI converter: constants, types and the key table.
`default_nettype none

package hkm_pkg;

    localparam int KEY_SLOTS     = 6;
    localparam int IN_KEY_FIELDS = 6;
    localparam int LANES         = 2 * KEY_SLOTS;

    localparam logic [7:0] STATUS_NOTE_OFF = 8'h80;
    localparam logic [7:0] STATUS_NOTE_ON  = 8'h90;
    localparam logic [6:0] VELOCITY_RESET  = 7'd100;

    localparam logic OP_REPORT = 1'b0;
    localparam logic OP_LOST   = 1'b1;

    typedef logic [KEY_SLOTS-1:0][7:0] t_keys;

    typedef struct packed {
        logic       hit;
        logic [6:0] note;
    } t_lane_res;

    typedef t_lane_res [LANES-1:0] t_lane_vec;

    // QWERTY piano layout, 0 = unmapped
    function automatic logic [6:0] note_of(input logic [7:0] code);
        logic [6:0] note;
        case (code)
            8'h05: note = 7'd67;
            8'h06: note = 7'd64;
            8'h07: note = 7'd63;
            8'h08: note = 7'd52;
            8'h0A: note = 7'd66;
            8'h0B: note = 7'd68;
            8'h0D: note = 7'd70;
            8'h10: note = 7'd71;
            8'h11: note = 7'd69;
            8'h14: note = 7'd48;
            8'h15: note = 7'd53;
            8'h16: note = 7'd61;
            8'h17: note = 7'd55;
            8'h18: note = 7'd59;
            8'h19: note = 7'd65;
            8'h1A: note = 7'd50;
            8'h1B: note = 7'd62;
            8'h1C: note = 7'd57;
            8'h1D: note = 7'd60;
            8'h1F: note = 7'd49;
            8'h20: note = 7'd51;
            8'h22: note = 7'd54;
            8'h23: note = 7'd56;
            8'h24: note = 7'd58;
            8'h36: note = 7'd72;
            default: note = 7'd0;
        endcase
        return note;
    endfunction

endpackage

`default_nettype wire

### src/hid_keyboard_report_to_midi_notes.sv
// Top level: HID boot-keyboard report diff to MIDI note-on/note-off messages.
// Input channel: i_valid / o_stall, one transfer carries i_op and six usage codes.
// i_op = 0 is a report, i_op = 1 (keyboard lost) clears the stored report, no output.
// Output channel: o_valid / i_stall, one transfer per MIDI message; o_last_event
// marks the last message of a report. Reports with no change give no transfer.
// Config channel: i_cfg_valid / o_cfg_ready (always ready) writes note-on velocity.
// Twelve compare lanes (six note-off, six note-on) judge a report in the cycle it
// is accepted; the merge stage emits one message per cycle unless stalled, note-offs first.
// A report's hits are registered in the pending mask, then each message in the output register.
// Throughput: a report with N messages (0..12) occupies the merge stage until the last launches;
// the next report is accepted in the cycle its predecessor's last message launches,
// so reports with no messages are taken every cycle.
// A stall from the receiver holds the output register and the pending messages;
// the input stall rises while messages are pending.
// Reset (synchronous, active low) clears the stored report, pending messages and
// output valid, and sets velocity to 100.
`default_nettype none

module hid_keyboard_report_to_midi_notes (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire logic       i_op,
    input  wire logic [7:0] i_key_0,
    input  wire logic [7:0] i_key_1,
    input  wire logic [7:0] i_key_2,
    input  wire logic [7:0] i_key_3,
    input  wire logic [7:0] i_key_4,
    input  wire logic [7:0] i_key_5,
    input  wire logic       i_cfg_valid,
    output logic            o_cfg_ready,
    input  wire logic [6:0] i_cfg_note_on_velocity,
    output logic            o_valid,
    input  wire logic       i_stall,
    output logic [7:0]      o_midi_status,
    output logic [6:0]      o_note_number,
    output logic [6:0]      o_velocity,
    output logic            o_last_event
);

    localparam int KS = hkm_pkg::KEY_SLOTS;
    localparam int NI = hkm_pkg::IN_KEY_FIELDS;

    logic [NI-1:0][7:0] in_keys;
    hkm_pkg::t_keys     fresh;
    hkm_pkg::t_keys     r_prev;
    logic [6:0]         r_velocity;
    hkm_pkg::t_lane_vec lanes, lanes_gated;
    logic               accept;

    assign in_keys = {i_key_5, i_key_4, i_key_3, i_key_2, i_key_1, i_key_0};

    for (genvar s = 0; s < KS; s++) begin : g_fresh
        if (s < NI) begin : g_in
            assign fresh[s] = in_keys[s];
        end else begin : g_empty
            assign fresh[s] = 8'd0;
        end
    end

    assign accept      = i_valid && !o_stall;
    assign o_cfg_ready = 1'b1;

    for (genvar s = 0; s < KS; s++) begin : g_lanes
        hkm_lane u_off (
            .i_code  (r_prev[s]),
            .i_other (fresh),
            .o_res   (lanes[s])
        );
        hkm_lane u_on (
            .i_code  (fresh[s]),
            .i_other (r_prev),
            .o_res   (lanes[KS + s])
        );
    end

    always_comb begin
        lanes_gated = lanes;
        for (int j = 0; j < hkm_pkg::LANES; j++) begin
            lanes_gated[j].hit = lanes[j].hit && (i_op == hkm_pkg::OP_REPORT);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev     <= '0;
            r_velocity <= hkm_pkg::VELOCITY_RESET;
        end else begin
            if (accept) begin
                r_prev <= (i_op == hkm_pkg::OP_LOST) ? '0 : fresh;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                r_velocity <= i_cfg_note_on_velocity;
            end
        end
    end

    hkm_merge u_merge (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (accept),
        .i_lanes       (lanes_gated),
        .i_velocity    (r_velocity),
        .i_stall       (i_stall),
        .o_stall       (o_stall),
        .o_valid       (o_valid),
        .o_midi_status (o_midi_status),
        .o_note_number (o_note_number),
        .o_velocity    (o_velocity),
        .o_last_event  (o_last_event)
    );

endmodule

`default_nettype wire

### src/hkm_lane.sv
// One compare lane: is a nonzero, mapped code absent from the other report, and which note it plays.
`default_nettype none

module hkm_lane (
    input  wire logic [7:0]     i_code,
    input  wire hkm_pkg::t_keys i_other,
    output hkm_pkg::t_lane_res  o_res
);

    logic [hkm_pkg::KEY_SLOTS-1:0] match;
    logic [6:0]                    note;

    always_comb begin
        for (int s = 0; s < hkm_pkg::KEY_SLOTS; s++) begin
            match[s] = (i_other[s] == i_code);
        end
    end

    assign note       = hkm_pkg::note_of(i_code);
    assign o_res.note = note;
    assign o_res.hit  = (i_code != 8'd0) && !(|match) && (note != 7'd0);

endmodule

`default_nettype wire

### src/hkm_merge.sv
// Merge stage: holds the lane hits of one report and sends them out one message per cycle unless the receiver stalls.
`default_nettype none

module hkm_merge (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_load,
    input  wire hkm_pkg::t_lane_vec i_lanes,
    input  wire logic [6:0]        i_velocity,
    input  wire logic              i_stall,
    output logic                   o_stall,
    output logic                   o_valid,
    output logic [7:0]             o_midi_status,
    output logic [6:0]             o_note_number,
    output logic [6:0]             o_velocity,
    output logic                   o_last_event
);

    localparam int LANES = hkm_pkg::LANES;
    localparam int KS    = hkm_pkg::KEY_SLOTS;

    logic [LANES-1:0]      r_mask, n_mask;
    logic [LANES-1:0][6:0] r_note;
    logic                  r_valid;
    logic [7:0]            r_status;
    logic [6:0]            r_note_out;
    logic [6:0]            r_vel;
    logic                  r_last;

    logic [LANES-1:0] pick;
    logic [LANES-1:0] hits;
    logic [6:0]       sel_note;
    logic             busy, launch, last, is_on;

    always_comb begin
        for (int j = 0; j < LANES; j++) begin
            hits[j] = i_lanes[j].hit;
        end
    end

    assign busy   = |r_mask;
    assign launch = busy && (!r_valid || !i_stall);
    assign pick   = r_mask & (~r_mask + 1'b1);
    assign last   = ((r_mask & ~pick) == '0);
    assign is_on  = |pick[LANES-1:KS];
    assign o_stall = busy && !(launch && last);

    always_comb begin
        sel_note = 7'd0;
        for (int j = 0; j < LANES; j++) begin
            sel_note = sel_note | (pick[j] ? r_note[j] : 7'd0);
        end
    end

    always_comb begin
        n_mask = r_mask;
        if (i_load) begin
            n_mask = hits;
        end else if (launch) begin
            n_mask = r_mask & ~pick;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_mask <= n_mask;
            if (launch) begin
                r_valid <= 1'b1;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            for (int j = 0; j < LANES; j++) begin
                r_note[j] <= i_lanes[j].note;
            end
        end
        if (launch) begin
            r_status   <= is_on ? hkm_pkg::STATUS_NOTE_ON : hkm_pkg::STATUS_NOTE_OFF;
            r_note_out <= sel_note;
            r_vel      <= is_on ? i_velocity : 7'd0;
            r_last     <= last;
        end
    end

    assign o_valid       = r_valid;
    assign o_midi_status = r_status;
    assign o_note_number = r_note_out;
    assign o_velocity    = r_vel;
    assign o_last_event  = r_last;

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> (!busy || (launch && last)))
        else $error("report loaded over pending messages");

    a_launch_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        launch |=> r_valid)
        else $error("launched message not presented");

    a_one_per_launch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_load && launch) |=> ($countones(r_mask) + 1 == $countones($past(r_mask))))
        else $error("pending mask lost or gained a message");

endmodule

`default_nettype wire
